// ----- design/dcp_pkg.sv -----
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared constants and types of the delta-correlating prefetcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dcp_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned HIST_DEPTH    = 8;
  localparam int unsigned ADDR_W        = 48;
  localparam int unsigned DELTA_W       = 32;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned HIDX_W        = $clog2(HIST_DEPTH);
  localparam int unsigned ENTRY_W       = 2 * ADDR_W + HIST_DEPTH * DELTA_W;

  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_ADDR_W    = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_ADDRESS_LIMIT = 4'h0;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DELTA_W-1:0] delta_t;
  typedef delta_t [HIST_DEPTH-1:0] hist_t;

  typedef struct packed {
    addr_t tag;
    addr_t last;
    hist_t hist;
  } entry_t;

  // replay start request from the table logic to the replay unit
  typedef struct packed {
    logic              start;
    hist_t             hist;
    logic [HIDX_W-1:0] first;
    addr_t             base;
  } replay_cmd_t;

endpackage

`default_nettype wire

// ----- design/dcp_table_ram.sv -----
// ----------------------------------------------------------------------------
// dcp_table_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_table_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/dcp_update.sv -----
// ----------------------------------------------------------------------------
// dcp_update
// Delta computation, history shift and search for the newest delta pair.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_update (
  input  wire dcp_pkg::addr_t              last_i,
  input  wire dcp_pkg::addr_t              addr_i,
  input  wire dcp_pkg::hist_t              hist_i,
  output dcp_pkg::hist_t                   hist_o,
  output logic                             match_o,
  output logic [dcp_pkg::HIDX_W-1:0]       match_idx_o
);

  localparam int unsigned HI_W = dcp_pkg::ADDR_W - dcp_pkg::DELTA_W + 1;

  dcp_pkg::addr_t  diff;
  logic            in_range;
  dcp_pkg::delta_t delta;

  assign diff     = addr_i - last_i;
  assign in_range = (diff[dcp_pkg::ADDR_W-1 -: HI_W] == '0) ||
                    (&diff[dcp_pkg::ADDR_W-1 -: HI_W]);
  assign delta    = in_range ? diff[dcp_pkg::DELTA_W-1:0] : '0;

  always_comb begin
    hist_o = hist_i;
    if (delta != '0) begin
      for (int i = dcp_pkg::HIST_DEPTH - 1; i > 0; i--) begin
        hist_o[i] = hist_i[i-1];
      end
      hist_o[0] = delta;
    end
  end

  // oldest position wins
  always_comb begin
    match_o     = 1'b0;
    match_idx_o = '0;
    for (int i = 3; i < dcp_pkg::HIST_DEPTH; i++) begin
      if (hist_o[i-1] == hist_o[0] && hist_o[i] == hist_o[1]) begin
        match_o     = 1'b1;
        match_idx_o = i[dcp_pkg::HIDX_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/dcp_replay.sv -----
// ----------------------------------------------------------------------------
// dcp_replay
// Replays the deltas that followed a matched pair, one per cycle unless output
// stalls, drops addresses at or above the limit and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_replay (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dcp_pkg::replay_cmd_t cmd_i,
  input  wire dcp_pkg::addr_t       limit_i,
  output logic                      idle_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output dcp_pkg::addr_t            m_addr_o,
  output logic                      m_last_o
);

  logic                        busy_q, busy_d;
  logic [dcp_pkg::HIDX_W-1:0]  k_q, k_d;
  dcp_pkg::addr_t              base_q, base_d;
  dcp_pkg::hist_t              hist_q, hist_d;
  logic                        pend_v_q, pend_v_d;
  dcp_pkg::addr_t              pend_q, pend_d;
  logic                        out_v_q, out_v_d;
  dcp_pkg::addr_t              out_q, out_d;
  logic                        last_q, last_d;

  dcp_pkg::delta_t cur;
  dcp_pkg::addr_t  cand;
  logic            pass;
  logic            out_free;

  assign cur      = hist_q[k_q];
  assign cand     = base_q + {{(dcp_pkg::ADDR_W - dcp_pkg::DELTA_W){cur[dcp_pkg::DELTA_W-1]}},
                              cur};
  assign pass     = cand < limit_i;
  assign out_free = !out_v_q || m_ready_i;

  always_comb begin
    busy_d   = busy_q;
    k_d      = k_q;
    base_d   = base_q;
    hist_d   = hist_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !m_ready_i;
    out_d    = out_q;
    last_d   = last_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      k_d    = cmd_i.first;
      base_d = cmd_i.base;
      hist_d = cmd_i.hist;
    end else if (busy_q) begin
      if (!pass || !pend_v_q || out_free) begin
        base_d = cand;
        k_d    = k_q - 1'b1;
        busy_d = (k_q != '0);
        if (pass) begin
          if (pend_v_q) begin
            out_v_d = 1'b1;
            out_d   = pend_q;
            last_d  = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_d   = cand;
        end
      end
    end else if (pend_v_q && out_free) begin
      out_v_d  = 1'b1;
      out_d    = pend_q;
      last_d   = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    base_q <= base_d;
    hist_q <= hist_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign idle_o    = !busy_q && !pend_v_q;
  assign m_valid_o = out_v_q;
  assign m_addr_o  = out_q;
  assign m_last_o  = last_q;

endmodule

`default_nettype wire

// ----- design/delta_correlating_prefetcher.sv -----
// ----------------------------------------------------------------------------
// delta_correlating_prefetcher
// Delta-correlating prefetcher with a direct-mapped, PC-tagged delta table.
// ----------------------------------------------------------------------------
// Each access request (instruction address, data address) indexes a 64-entry
// table held in one synchronous RAM; valid bits sit in flip-flops, so no
// clearing pass follows reset. The block serves one access at a time: the
// table read is registered, and the update and write-back follow in the
// lookup state, after which an access without prediction is done. With a
// prediction, the replay unit adds one delta per cycle, up to 6, while the
// output side keeps up, then flushes the final prefetch; the control returns
// to idle once it sees the replay unit idle. Back-pressure on the result
// stream stretches the replay.
// address_limit is at byte address 0 of the APB port.
`default_nettype none

module delta_correlating_prefetcher (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // access requests: [47:0] instr_address, [95:48] data_address
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [2*dcp_pkg::ADDR_W-1:0]       s_axis_tdata,
  // prefetches: [47:0] prefetch_address; tlast is last_of_run
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [dcp_pkg::ADDR_W-1:0]              m_axis_tdata,
  output logic                                    m_axis_tlast,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dcp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [dcp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dcp_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                    pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_REPLAY = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [dcp_pkg::TABLE_ENTRIES-1:0] valid_q, valid_d;
  dcp_pkg::addr_t                  limit_q, limit_d;
  dcp_pkg::addr_t                  pc_q, pc_d;
  dcp_pkg::addr_t                  addr_q, addr_d;

  logic                            accept;
  logic [dcp_pkg::IDX_W-1:0]       idx;
  logic [dcp_pkg::ENTRY_W-1:0]     rdata;
  dcp_pkg::entry_t                 rd_entry;
  dcp_pkg::entry_t                 wr_entry;
  logic                            hit;
  logic                            we;
  dcp_pkg::hist_t                  upd_hist;
  logic                            match;
  logic [dcp_pkg::HIDX_W-1:0]      match_idx;
  dcp_pkg::replay_cmd_t            cmd;
  logic                            replay_idle;
  logic                            cfg_we;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign idx           = pc_q[dcp_pkg::IDX_W-1:0];
  assign rd_entry      = dcp_pkg::entry_t'(rdata);
  assign hit           = valid_q[idx] && (rd_entry.tag == pc_q);
  assign we            = (state_q == ST_LOOKUP);

  dcp_table_ram #(
    .DEPTH (dcp_pkg::TABLE_ENTRIES),
    .WIDTH (dcp_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (wr_entry),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[dcp_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  dcp_update u_update (
    .last_i      (rd_entry.last),
    .addr_i      (addr_q),
    .hist_i      (rd_entry.hist),
    .hist_o      (upd_hist),
    .match_o     (match),
    .match_idx_o (match_idx)
  );

  always_comb begin
    wr_entry.tag  = pc_q;
    wr_entry.last = addr_q;
    wr_entry.hist = hit ? upd_hist : '0;
  end

  always_comb begin
    cmd.start = (state_q == ST_LOOKUP) && hit && match;
    cmd.hist  = upd_hist;
    cmd.first = match_idx - dcp_pkg::HIDX_W'(2);
    cmd.base  = addr_q;
  end

  dcp_replay u_replay (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .limit_i   (limit_q),
    .idle_o    (replay_idle),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_addr_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    pc_d    = pc_q;
    addr_d  = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pc_d    = s_axis_tdata[dcp_pkg::ADDR_W-1:0];
          addr_d  = s_axis_tdata[2*dcp_pkg::ADDR_W-1:dcp_pkg::ADDR_W];
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        valid_d[idx] = 1'b1;
        state_d      = cmd.start ? ST_REPLAY : ST_IDLE;
      end
      ST_REPLAY: begin
        if (replay_idle) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == dcp_pkg::REG_ADDRESS_LIMIT);

  always_comb begin
    limit_d = limit_q;
    if (cfg_we) begin
      limit_d = pwdata[dcp_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == dcp_pkg::REG_ADDRESS_LIMIT) begin
      prdata = {{(dcp_pkg::CFG_DATA_W - dcp_pkg::ADDR_W){1'b0}}, limit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      limit_q <= '1;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q   <= pc_d;
    addr_q <= addr_d;
  end

endmodule

`default_nettype wire

// ----- verif/tb_delta_correlating_prefetcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_correlating_prefetcher
// Self-checking bench for the delta-correlating prefetcher.
// ----------------------------------------------------------------------------
// Access requests go in on the slave stream and a predictor of its own keeps a
// copy of the PC-tagged delta table. Every accepted request is predicted at the
// moment it is taken, and the prefetches it should cause are queued. Each
// prefetch on the master stream is checked against the oldest one queued
// (address and run end). A short directed run covers zero, wrapping and
// out-of-range deltas, the all-zero history of a fresh entry, slot conflicts
// and replay near the top of the address space. Random runs follow, mostly
// repeating delta patterns per PC, under several address limits, with random
// gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_delta_correlating_prefetcher;

  typedef struct {
    dcp_pkg::addr_t pc;
    dcp_pkg::addr_t data;
  } access_t;

  typedef struct {
    dcp_pkg::addr_t addr;
    logic           is_last;
  } prefetch_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [2*dcp_pkg::ADDR_W-1:0]       s_axis_tdata = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [dcp_pkg::ADDR_W-1:0]         m_axis_tdata;
  logic                               m_axis_tlast;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [dcp_pkg::CFG_ADDR_W-1:0]     paddr = '0;
  logic [dcp_pkg::CFG_DATA_W-1:0]     pwdata = '0;
  logic [dcp_pkg::CFG_DATA_W-1:0]     prdata;
  logic                               pready;

  delta_correlating_prefetcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb_delta_correlating_prefetcher: done, errors");
    $finish;
  end

  // predictor state
  dcp_pkg::addr_t  addr_limit = '1;
  bit              slot_valid [dcp_pkg::TABLE_ENTRIES];
  dcp_pkg::addr_t  slot_tag   [dcp_pkg::TABLE_ENTRIES];
  dcp_pkg::addr_t  slot_last  [dcp_pkg::TABLE_ENTRIES];
  dcp_pkg::delta_t slot_hist  [dcp_pkg::TABLE_ENTRIES][dcp_pkg::HIST_DEPTH];

  access_t     access_queue [$];
  prefetch_t   expected_prefetches [$];
  int unsigned errors = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  // generator bookkeeping
  dcp_pkg::addr_t gen_last [dcp_pkg::addr_t];
  dcp_pkg::addr_t pc_pool [$];
  int unsigned    queued_count = 0;

  function automatic void predict_prefetches(input dcp_pkg::addr_t pc,
                                             input dcp_pkg::addr_t addr);
    int unsigned     slot;
    dcp_pkg::addr_t  diff;
    dcp_pkg::addr_t  base;
    dcp_pkg::delta_t step;
    int              hit_at;
    prefetch_t       run [$];
    slot = 32'(pc[dcp_pkg::IDX_W-1:0]);
    if (!slot_valid[slot] || slot_tag[slot] != pc) begin
      slot_valid[slot] = 1'b1;
      slot_tag[slot]   = pc;
      slot_last[slot]  = addr;
      for (int j = 0; j < dcp_pkg::HIST_DEPTH; j++) slot_hist[slot][j] = '0;
      return;
    end
    diff = addr - slot_last[slot];
    if (diff >= 48'h0000_8000_0000 && diff < 48'hFFFF_8000_0000) diff = '0;
    if (diff != '0) begin
      for (int j = dcp_pkg::HIST_DEPTH - 1; j > 0; j--)
        slot_hist[slot][j] = slot_hist[slot][j-1];
      slot_hist[slot][0] = diff[dcp_pkg::DELTA_W-1:0];
    end
    slot_last[slot] = addr;
    hit_at = 0;
    for (int i = dcp_pkg::HIST_DEPTH - 1; i > 2 && hit_at == 0; i--) begin
      if (slot_hist[slot][i-1] == slot_hist[slot][0] &&
          slot_hist[slot][i] == slot_hist[slot][1]) hit_at = i;
    end
    if (hit_at == 0) return;
    base = addr;
    for (int k = hit_at - 2; k >= 0; k--) begin
      step = slot_hist[slot][k];
      base = base + {{(dcp_pkg::ADDR_W-dcp_pkg::DELTA_W){step[dcp_pkg::DELTA_W-1]}}, step};
      if (base < addr_limit) run.push_back('{base, 1'b0});
    end
    if (run.size() != 0) run[run.size()-1].is_last = 1'b1;
    foreach (run[j]) expected_prefetches.push_back(run[j]);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic dcp_pkg::addr_t rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[dcp_pkg::ADDR_W-1:0];
  endfunction

  function automatic dcp_pkg::addr_t pick_delta();
    dcp_pkg::addr_t d;
    logic [31:0]    w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: d = dcp_pkg::addr_t'(64 * $urandom_range(1, 64));
      5:             d = '0;
      6:             d = dcp_pkg::addr_t'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      7: begin
        case ($urandom_range(0, 3))
          0:       d = 48'h0000_7FFF_FFFF;
          1:       d = 48'hFFFF_8000_0000;
          2:       d = 48'h0000_8000_0000;
          default: d = 48'hFFFF_7FFF_FFFF;
        endcase
      end
      8: begin
        w = $urandom();
        d = {{(dcp_pkg::ADDR_W-32){w[31]}}, w};
      end
      default:       d = rand_addr();
    endcase
    if ($urandom_range(0, 1) == 1) d = '0 - d;
    return d;
  endfunction

  function automatic dcp_pkg::addr_t pick_start(input dcp_pkg::addr_t centre);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return rand_addr();
    if (r < 7) return centre - dcp_pkg::addr_t'(64 * $urandom_range(0, 2048));
    return '0 - dcp_pkg::addr_t'($urandom_range(1, 8192));
  endfunction

  task automatic queue_access(input dcp_pkg::addr_t pc, input dcp_pkg::addr_t addr);
    access_queue.push_back('{pc, addr});
    gen_last[pc] = addr;
    queued_count++;
  endtask

  task automatic play_pattern(input dcp_pkg::addr_t pc, input dcp_pkg::addr_t start,
                              input int unsigned steps, input int unsigned period,
                              input bit broken);
    dcp_pkg::addr_t deltas [6];
    dcp_pkg::addr_t addr;
    for (int j = 0; j < period; j++) deltas[j] = pick_delta();
    addr = start;
    queue_access(pc, addr);
    for (int unsigned s = 0; s < steps; s++) begin
      addr = addr + deltas[s % period];
      if (broken && s == steps / 2) addr = addr + pick_delta();
      queue_access(pc, addr);
      if ($urandom_range(0, 9) == 0) queue_access(rand_addr(), rand_addr());
    end
  endtask

  task automatic random_accesses(input int unsigned n, input dcp_pkg::addr_t centre);
    int unsigned    target;
    int unsigned    r;
    int unsigned    period;
    dcp_pkg::addr_t pc;
    dcp_pkg::addr_t start;
    target = queued_count + n;
    while (queued_count < target) begin
      r = $urandom_range(0, 9);
      if (pc_pool.size() != 0 && $urandom_range(0, 1) == 1) begin
        pc = pc_pool[$urandom_range(0, pc_pool.size() - 1)];
      end else begin
        pc = rand_addr();
        pc_pool.push_back(pc);
        if (pc_pool.size() > 8) void'(pc_pool.pop_front());
      end
      if (gen_last.exists(pc) && $urandom_range(0, 1) == 1) start = gen_last[pc];
      else start = pick_start(centre);
      period = $urandom_range(1, 6);
      if (r <= 6) begin
        play_pattern(pc, start, $urandom_range(period + 2, 14), period, 1'b0);
      end else if (r == 7) begin
        queue_access(rand_addr(), rand_addr());
      end else if (r == 8) begin
        queue_access(pc, start + pick_delta());
      end else begin
        play_pattern(pc, start, $urandom_range(period + 2, 14), period, 1'b1);
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (access_queue.size() != 0 || s_axis_tvalid || expected_prefetches.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_limit(input dcp_pkg::addr_t value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dcp_pkg::REG_ADDRESS_LIMIT;
    pwdata  <= {{(dcp_pkg::CFG_DATA_W-dcp_pkg::ADDR_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    addr_limit = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    if (prdata !== {{(dcp_pkg::CFG_DATA_W-dcp_pkg::ADDR_W){1'b0}}, value}) begin
      errors++;
      if (errors <= 10)
        $display("limit readback mismatch: expected %h, got %h", value, prdata);
    end
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_requests
    access_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_prefetches(s_axis_tdata[dcp_pkg::ADDR_W-1:0],
                           s_axis_tdata[2*dcp_pkg::ADDR_W-1:dcp_pkg::ADDR_W]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (access_queue.size() != 0) begin
          nxt = access_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.data, nxt.pc};
          send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // prefetch monitor
  always @(posedge clk_i) begin : check_prefetches
    prefetch_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_prefetches.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected prefetch %h last %b", m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_prefetches.pop_front();
          if (m_axis_tdata !== want.addr || m_axis_tlast !== want.is_last) begin
            errors++;
            if (errors <= 10)
              $display("prefetch mismatch: expected %h last %b, got %h last %b",
                       want.addr, want.is_last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    dcp_pkg::addr_t mid;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: fresh entries, zero history match, wrap and range edges of deltas
    queue_access(48'h0, 48'h0);
    queue_access(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_access(48'h0, 48'h0);
    queue_access(48'hFFFF_FFFF_FFFF, 48'h0);
    queue_access(48'h123, 48'h1234_5678_9A00);
    queue_access(48'h123, 48'h1234_D678_9A00);
    queue_access(48'h123, 48'h1234_5678_9A00);
    queue_access(48'h123, 48'h1234_D678_99FF);
    // two-delta pattern replayed near the top of the address space
    begin
      dcp_pkg::addr_t walk;
      walk = 48'hFFFF_FFFF_F000;
      queue_access(48'hABC_DEF0_1234, walk);
      for (int s = 0; s < 6; s++) begin
        walk = walk + ((s % 2 == 0) ? 48'h400 : 48'hFFFF_FFFF_FF00);
        queue_access(48'hABC_DEF0_1234, walk);
      end
    end
    // slot conflicts
    queue_access(48'h200, 48'h5000);
    queue_access(48'h240, 48'h6000);
    queue_access(48'h200, 48'h5040);
    queue_access(48'h0, 48'h0);
    wait_quiet();

    steady = 1'b0;
    write_limit(48'h0);
    random_accesses(40, 48'h0);
    wait_quiet();

    mid = rand_addr();
    write_limit(mid);
    random_accesses(120, mid);
    wait_quiet();

    steady = 1'b1;
    write_limit(48'hFFFF_FFFF_FFFF);
    random_accesses(120, 48'h8000_0000_0000);
    wait_quiet();

    steady = 1'b0;
    write_limit(48'h0000_0000_1000);
    random_accesses(110, 48'h0000_0000_1000);
    wait_quiet();

    if (errors == 0)
      $display("tb_delta_correlating_prefetcher: done, clean");
    else
      $display("tb_delta_correlating_prefetcher: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/dcp_pkg.sv
design/dcp_table_ram.sv
design/dcp_update.sv
design/dcp_replay.sv
design/delta_correlating_prefetcher.sv
verif/tb_delta_correlating_prefetcher.sv
